// ===== hdl/bayer_sqrt_variance_stabilizer_unit_defines.svh =====
// assertion macros shared by the stabilizer rtl
`ifndef BAYER_SQRT_VARIANCE_STABILIZER_UNIT_DEFINES_SVH
`define BAYER_SQRT_VARIANCE_STABILIZER_UNIT_DEFINES_SVH

// condition and consequence checked on the same edge
`define BSVS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// consequence checked at the edge following the condition
`define BSVS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/bsvs_pkg.sv =====
package bsvs_pkg;

    localparam int SAMPLE_BITS     = 16;
    localparam int OFFSET_BITS     = 41;
    localparam int GAIN_BITS       = 24;
    localparam int PROD_BITS       = GAIN_BITS + SAMPLE_BITS + 1;
    localparam int ARG_BITS        = OFFSET_BITS + 1;
    localparam int ROOT_BITS       = ARG_BITS / 2;
    localparam int REM_BITS        = ROOT_BITS + 1;
    localparam int STEPS_PER_STAGE = 3;
    localparam int SQRT_STAGES     = ROOT_BITS / STEPS_PER_STAGE;
    // input, product, argument, then one stage per group of root bits
    localparam int NUM_STAGES      = SQRT_STAGES + 3;

    localparam int CFG_INDEX_BITS  = 3;
    localparam int CFG_DATA_BITS   = OFFSET_BITS;
    localparam int TDATA_IN_BITS   = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int TDATA_OUT_BITS  = ((ROOT_BITS + 7) / 8) * 8;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_RED_OFFSET   = 3'd0,
        REG_RED_GAIN     = 3'd1,
        REG_GREEN_OFFSET = 3'd2,
        REG_GREEN_GAIN   = 3'd3,
        REG_BLUE_OFFSET  = 3'd4,
        REG_BLUE_GAIN    = 3'd5
    } cfg_reg_t;

    localparam logic signed [GAIN_BITS-1:0]   GAIN_RESET   = GAIN_BITS'(65536);
    localparam logic signed [OFFSET_BITS-1:0] OFFSET_RESET = '0;

    typedef struct packed {
        logic [ARG_BITS-1:0]  x;
        logic [REM_BITS-1:0]  rem;
        logic [ROOT_BITS-1:0] root;
    } sqrt_state_t;

endpackage

// ===== hdl/bayer_sqrt_variance_stabilizer_unit.sv =====
// Square-root variance stabilizer for raw Bayer pixels. Each beat on the s_ side carries one
// 16-bit sample and its column and row parity; even/even uses the red registers, odd/odd the
// blue ones and the mixed parities the green ones. The block returns floor(sqrt(offset +
// gain * sample)) as unsigned Q13.8 on m_tdata, or 0 with m_tuser set when the argument is
// negative. Gains are signed Q8.16 and offsets signed Q25.16, written through the cfg port
// (index 0..5: red offset, red gain, green offset, green gain, blue offset, blue gain; other
// indexes are dropped); the user must do so only while no pixel is in flight, which the block
// does not enforce. One pixel is taken per clock unless m_tready stalls the full pipe, which
// holds one input register, a register after the 24x17 multiply, one after the offset add and
// seven square-root stages resolving three root bits each. Every stage has its own valid bit,
// so bubbles close up while m_tready is low and s_tready only falls once the whole pipe is full.
`include "bayer_sqrt_variance_stabilizer_unit_defines.svh"

module bayer_sqrt_variance_stabilizer_unit (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    input  logic [bsvs_pkg::TDATA_IN_BITS-1:0]      s_tdata,   // [15:0] sample
    input  logic [1:0]                              s_tuser,   // [0] col_odd, [1] row_odd
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    output logic [bsvs_pkg::TDATA_OUT_BITS-1:0]     m_tdata,   // [20:0] stabilized, rest zero
    output logic [0:0]                              m_tuser,   // [0] clamped
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [bsvs_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
    input  logic [bsvs_pkg::CFG_DATA_BITS-1:0]      cfg_data
);

    localparam int NS = bsvs_pkg::NUM_STAGES;
    localparam int SQ = bsvs_pkg::SQRT_STAGES;

    // configuration
    logic signed [bsvs_pkg::OFFSET_BITS-1:0] red_offset_reg, green_offset_reg, blue_offset_reg;
    logic signed [bsvs_pkg::GAIN_BITS-1:0]   red_gain_reg, green_gain_reg, blue_gain_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            red_offset_reg   <= bsvs_pkg::OFFSET_RESET;
            green_offset_reg <= bsvs_pkg::OFFSET_RESET;
            blue_offset_reg  <= bsvs_pkg::OFFSET_RESET;
            red_gain_reg     <= bsvs_pkg::GAIN_RESET;
            green_gain_reg   <= bsvs_pkg::GAIN_RESET;
            blue_gain_reg    <= bsvs_pkg::GAIN_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                bsvs_pkg::REG_RED_OFFSET:   red_offset_reg   <= cfg_data;
                bsvs_pkg::REG_RED_GAIN:     red_gain_reg     <= cfg_data[bsvs_pkg::GAIN_BITS-1:0];
                bsvs_pkg::REG_GREEN_OFFSET: green_offset_reg <= cfg_data;
                bsvs_pkg::REG_GREEN_GAIN:   green_gain_reg   <= cfg_data[bsvs_pkg::GAIN_BITS-1:0];
                bsvs_pkg::REG_BLUE_OFFSET:  blue_offset_reg  <= cfg_data;
                bsvs_pkg::REG_BLUE_GAIN:    blue_gain_reg    <= cfg_data[bsvs_pkg::GAIN_BITS-1:0];
                default: ;
            endcase
        end
    end

    // pipeline flow control: a stage loads when it is empty or its content moves on
    logic [NS-1:0] valid_reg;
    logic [NS:0]   stage_ready;

    always_comb begin
        stage_ready[NS] = m_tready;
        for (int i = NS - 1; i >= 0; i--) begin
            stage_ready[i] = !valid_reg[i] || stage_ready[i+1];
        end
    end

    assign s_tready = stage_ready[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (stage_ready[0]) begin
                valid_reg[0] <= s_tvalid;
            end
            for (int i = 1; i < NS; i++) begin
                if (stage_ready[i]) begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    // stage 0: channel pick and input register
    logic                                    green_sel, blue_sel;
    logic [bsvs_pkg::SAMPLE_BITS-1:0]        smp_reg;
    logic signed [bsvs_pkg::GAIN_BITS-1:0]   gain_reg, gain_next;
    logic signed [bsvs_pkg::OFFSET_BITS-1:0] ofs_a_reg, ofs_a_next;

    assign green_sel = s_tuser[0] ^ s_tuser[1];
    assign blue_sel  = s_tuser[0] & s_tuser[1];

    always_comb begin
        if (green_sel) begin
            gain_next  = green_gain_reg;
            ofs_a_next = green_offset_reg;
        end else if (blue_sel) begin
            gain_next  = blue_gain_reg;
            ofs_a_next = blue_offset_reg;
        end else begin
            gain_next  = red_gain_reg;
            ofs_a_next = red_offset_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_ready[0]) begin
            smp_reg   <= s_tdata[bsvs_pkg::SAMPLE_BITS-1:0];
            gain_reg  <= gain_next;
            ofs_a_reg <= ofs_a_next;
        end
    end

    // stage 1: gain times sample
    logic signed [bsvs_pkg::PROD_BITS-1:0]   prod_reg, prod_next;
    logic signed [bsvs_pkg::OFFSET_BITS-1:0] ofs_b_reg;

    assign prod_next = bsvs_pkg::PROD_BITS'(gain_reg)
                     * bsvs_pkg::PROD_BITS'($signed({1'b0, smp_reg}));

    always_ff @(posedge aclk) begin
        if (stage_ready[1]) begin
            prod_reg  <= prod_next;
            ofs_b_reg <= ofs_a_reg;
        end
    end

    // stage 2: argument, negative ones go on as zero
    logic signed [bsvs_pkg::ARG_BITS-1:0] arg_next;
    bsvs_pkg::sqrt_state_t                sq_reg [SQ+1];
    bsvs_pkg::sqrt_state_t                sq_next [SQ+1];
    logic [SQ:0]                          clamp_reg;

    assign arg_next = {ofs_b_reg[bsvs_pkg::OFFSET_BITS-1], ofs_b_reg}
                    + {{(bsvs_pkg::ARG_BITS - bsvs_pkg::PROD_BITS){prod_reg[bsvs_pkg::PROD_BITS-1]}},
                       prod_reg};

    always_comb begin
        sq_next[0].x    = arg_next[bsvs_pkg::ARG_BITS-1] ? '0 : arg_next;
        sq_next[0].rem  = '0;
        sq_next[0].root = '0;
    end

    always_ff @(posedge aclk) begin
        if (stage_ready[2]) begin
            sq_reg[0]    <= sq_next[0];
            clamp_reg[0] <= arg_next[bsvs_pkg::ARG_BITS-1];
        end
    end

    // square root, two argument bits and one root bit per step
    function automatic bsvs_pkg::sqrt_state_t sqrt_steps(input bsvs_pkg::sqrt_state_t st);
        bsvs_pkg::sqrt_state_t      s;
        logic [bsvs_pkg::REM_BITS+1:0] cur;
        logic [bsvs_pkg::REM_BITS+1:0] trial;
        s = st;
        for (int k = 0; k < bsvs_pkg::STEPS_PER_STAGE; k++) begin
            cur   = {s.rem, s.x[bsvs_pkg::ARG_BITS-1 -: 2]};
            trial = {1'b0, s.root, 2'b01};
            s.x   = {s.x[bsvs_pkg::ARG_BITS-3:0], 2'b00};
            if (cur >= trial) begin
                cur    = cur - trial;
                s.rem  = cur[bsvs_pkg::REM_BITS-1:0];
                s.root = {s.root[bsvs_pkg::ROOT_BITS-2:0], 1'b1};
            end else begin
                s.rem  = cur[bsvs_pkg::REM_BITS-1:0];
                s.root = {s.root[bsvs_pkg::ROOT_BITS-2:0], 1'b0};
            end
        end
        return s;
    endfunction

    for (genvar g = 1; g <= SQ; g++) begin : g_sqrt
        assign sq_next[g] = sqrt_steps(sq_reg[g-1]);

        always_ff @(posedge aclk) begin
            if (stage_ready[g+2]) begin
                sq_reg[g]    <= sq_next[g];
                clamp_reg[g] <= clamp_reg[g-1];
            end
        end
    end

    assign m_tvalid = valid_reg[NS-1];
    assign m_tdata  = {{(bsvs_pkg::TDATA_OUT_BITS - bsvs_pkg::ROOT_BITS){1'b0}}, sq_reg[SQ].root};
    assign m_tuser  = clamp_reg[SQ];

    `BSVS_ASSERT_NOW(a_clamp_gives_zero, m_tvalid && m_tuser[0], m_tdata == '0, "clamped result is not zero")
    `BSVS_ASSERT_NOW(a_root_remainder_bound, m_tvalid, {1'b0, sq_reg[SQ].rem} <= {1'b0, sq_reg[SQ].root, 1'b0}, "square root remainder above twice the root")
    `BSVS_ASSERT_NEXT(a_occupancy_grows, aresetn && s_tvalid && s_tready && !(m_tvalid && m_tready), $countones(valid_reg) == $past($countones(valid_reg)) + 1, "accepted beat not held in the pipeline")

endmodule

// ===== dv/bayer_sqrt_variance_stabilizer_unit_tb.sv =====
module bayer_sqrt_variance_stabilizer_unit_tb;
    import bsvs_pkg::*;

    localparam int CLK_HALF        = 4;
    localparam int PIPE_LATENCY    = 10;
    localparam int RX_HOLD_CYCLES  = 300;
    localparam int SILENCE_LIMIT   = 4000;
    localparam int RANDOM_PHASES   = 8;
    localparam int PHASE_PIXELS    = 80;
    localparam int CLOSING_PIXELS  = 100;

    // indexes past the register list, writes there must be dropped
    localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_HI = 3'd7;

    localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = {1'b0, {(OFFSET_BITS-1){1'b1}}};
    localparam logic [OFFSET_BITS-1:0] OFFSET_MIN = {1'b1, {(OFFSET_BITS-1){1'b0}}};
    localparam logic [GAIN_BITS-1:0]   GAIN_MAX   = {1'b0, {(GAIN_BITS-1){1'b1}}};
    localparam logic [GAIN_BITS-1:0]   GAIN_MIN   = {1'b1, {(GAIN_BITS-1){1'b0}}};

    typedef enum int {
        CH_RED   = 0,
        CH_GREEN = 1,
        CH_BLUE  = 2
    } chan_t;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] sample;
        logic                   col_odd;
        logic                   row_odd;
    } pixel_t;

    typedef struct packed {
        logic [ROOT_BITS-1:0] stabilized;
        logic                 clamped;
    } root_t;

    logic                          aclk      = 1'b0;
    logic                          aresetn   = 1'b0;
    logic                          s_tvalid  = 1'b0;
    logic                          s_tready;
    logic [TDATA_IN_BITS-1:0]      s_tdata   = '0;   // [15:0] sample
    logic [1:0]                    s_tuser   = '0;   // [0] col_odd, [1] row_odd
    logic                          m_tvalid;
    logic                          m_tready  = 1'b0;
    logic [TDATA_OUT_BITS-1:0]     m_tdata;          // [20:0] stabilized
    logic [0:0]                    m_tuser;          // [0] clamped
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [CFG_INDEX_BITS-1:0]     cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]      cfg_data  = '0;

    logic signed [OFFSET_BITS-1:0] offset_cfg [3];
    logic signed [GAIN_BITS-1:0]   gain_cfg   [3];

    pixel_t pending_pixels [$];
    root_t  expected_roots [$];
    pixel_t tx_pixel;
    root_t  rx_want;
    int     tx_gap        = 0;
    int     rx_stall      = 0;
    int     rx_hold       = 0;
    int     hold_token    = 0;
    int     hold_seen     = 0;
    int     idle_pct      = 0;
    int     fail_count    = 0;
    int     silent_cycles = 0;

    bayer_sqrt_variance_stabilizer_unit DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #CLK_HALF aclk = 1'b1;
        #CLK_HALF aclk = 1'b0;
    end

    // floor square root of offset + gain * sample for the pixel's channel
    function automatic root_t stabilize(pixel_t px);
        chan_t             ch;
        longint            off;
        longint            gn;
        longint            smp;
        longint            arg;
        longint unsigned   rad;
        longint unsigned   root;
        longint unsigned   trial;
        root_t             res;
        ch   = chan_t'(int'(px.col_odd) + int'(px.row_odd));
        off  = offset_cfg[ch];
        gn   = gain_cfg[ch];
        smp  = longint'({1'b0, px.sample});
        arg  = off + gn * smp;
        res  = '0;
        if (arg < 0) begin
            res.clamped = 1'b1;
        end else begin
            rad  = arg;
            root = 0;
            for (int b = ROOT_BITS - 1; b >= 0; b--) begin
                trial = root | (64'd1 << b);
                if (trial * trial <= rad) begin
                    root = trial;
                end
            end
            res.stabilized = root[ROOT_BITS-1:0];
        end
        return res;
    endfunction

    function automatic logic [OFFSET_BITS-1:0] pick_offset();
        logic [63:0]        w;
        logic signed [31:0] near;
        w    = {$urandom, $urandom};
        near = $urandom;
        case ($urandom_range(0, 7))
            0: return OFFSET_MAX;
            1: return OFFSET_MIN;
            2: return '0;
            3, 4: return w[OFFSET_BITS-1:0];
            default: return OFFSET_BITS'(near);
        endcase
    endfunction

    // gain in the low bits, junk above the register width
    function automatic logic [CFG_DATA_BITS-1:0] pick_gain_word();
        logic [63:0]        w;
        logic signed [17:0] near;
        logic [GAIN_BITS-1:0] g;
        w    = {$urandom, $urandom};
        near = 18'($urandom);
        case ($urandom_range(0, 7))
            0: g = GAIN_MAX;
            1: g = GAIN_MIN;
            2: g = '0;
            3: g = GAIN_RESET;
            4: g = w[GAIN_BITS-1:0];
            default: g = GAIN_BITS'(near);
        endcase
        return {w[63:64-(CFG_DATA_BITS-GAIN_BITS)], g};
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2, 3: return SAMPLE_BITS'($urandom_range(0, 255));
            default: return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    task automatic push_pixel(input logic [SAMPLE_BITS-1:0] smp, input logic col, input logic row);
        pixel_t px;
        px.sample  = smp;
        px.col_odd = col;
        px.row_odd = row;
        pending_pixels.push_back(px);
    endtask

    task automatic push_random(input int count);
        for (int i = 0; i < count; i++) begin
            push_pixel(pick_sample(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end
    endtask

    task automatic wait_drained();
        while (pending_pixels.size() != 0 || s_tvalid || expected_roots.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    // holds cfg_valid high, the caller lowers it once the batch is done
    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_RED_OFFSET:   offset_cfg[CH_RED]   = val;
            REG_RED_GAIN:     gain_cfg[CH_RED]     = val[GAIN_BITS-1:0];
            REG_GREEN_OFFSET: offset_cfg[CH_GREEN] = val;
            REG_GREEN_GAIN:   gain_cfg[CH_GREEN]   = val[GAIN_BITS-1:0];
            REG_BLUE_OFFSET:  offset_cfg[CH_BLUE]  = val;
            REG_BLUE_GAIN:    gain_cfg[CH_BLUE]    = val[GAIN_BITS-1:0];
            default: ;
        endcase
    endtask

    task automatic program_random();
        write_reg(REG_RED_OFFSET, pick_offset());
        write_reg(REG_RED_GAIN, pick_gain_word());
        if ($urandom_range(0, 2) == 0) begin
            write_reg($urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO,
                      CFG_DATA_BITS'({$urandom, $urandom}));
        end
        write_reg(REG_GREEN_OFFSET, pick_offset());
        write_reg(REG_GREEN_GAIN, pick_gain_word());
        write_reg(REG_BLUE_OFFSET, pick_offset());
        write_reg(REG_BLUE_GAIN, pick_gain_word());
        cfg_valid <= 1'b0;
    endtask

    // sender: one pixel per beat, random gaps after a beat
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            tx_gap    = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_roots.push_back(stabilize(tx_pixel));
            end
            if (!s_tvalid || s_tready) begin
                if (tx_gap != 0) begin
                    tx_gap--;
                    s_tvalid <= 1'b0;
                end else if (pending_pixels.size() != 0) begin
                    tx_pixel  = pending_pixels.pop_front();
                    s_tdata  <= tx_pixel.sample;
                    s_tuser  <= {tx_pixel.row_odd, tx_pixel.col_odd};
                    s_tvalid <= 1'b1;
                    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
                        tx_gap = $urandom_range(1, 15);
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver: checks each result beat, stalls in bursts or for a long hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_roots.size() == 0) begin
                    $error("result beat with nothing expected: stabilized %0d clamped %0b",
                           m_tdata, m_tuser[0]);
                    fail_count++;
                end else begin
                    rx_want = expected_roots.pop_front();
                    if (m_tdata !== TDATA_OUT_BITS'(rx_want.stabilized)) begin
                        $error("stabilized: expected %0d, got %0d", rx_want.stabilized, m_tdata);
                        fail_count++;
                    end
                    if (m_tuser[0] !== rx_want.clamped) begin
                        $error("clamped: expected %0b, got %0b", rx_want.clamped, m_tuser[0]);
                        fail_count++;
                    end
                end
            end
            if (hold_seen != hold_token) begin
                hold_seen = hold_token;
                rx_hold   = RX_HOLD_CYCLES;
            end
            if (rx_hold != 0) begin
                rx_hold--;
                m_tready <= 1'b0;
            end else if (rx_stall != 0) begin
                rx_stall--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
                    rx_stall = $urandom_range(1, 15);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready)) begin
            silent_cycles <= 0;
        end else if (silent_cycles >= SILENCE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            silent_cycles <= silent_cycles + 1;
        end
    end

    initial begin
        for (int c = CH_RED; c <= CH_BLUE; c++) begin
            offset_cfg[c] = OFFSET_RESET;
            gain_cfg[c]   = GAIN_RESET;
        end
        repeat (2) @(posedge aclk);
        aresetn  <= 1'b1;
        idle_pct <= 15;

        // reset gains of one, every parity, sample extremes
        push_pixel('0, 1'b0, 1'b0);
        push_pixel('1, 1'b1, 1'b0);
        push_pixel('1, 1'b0, 1'b1);
        push_pixel(16'd1, 1'b1, 1'b1);
        push_pixel(16'hAAAA, 1'b0, 1'b0);
        push_pixel(16'h5555, 1'b1, 1'b1);
        wait_drained();

        // largest argument on red, most negative on green, blue crosses zero at 100
        write_reg(REG_RED_OFFSET, OFFSET_MAX);
        write_reg(REG_RED_GAIN, {17'h1FFFF, GAIN_MAX});
        write_reg(REG_GREEN_OFFSET, OFFSET_MIN);
        write_reg(REG_GREEN_GAIN, {17'h15555, GAIN_MIN});
        write_reg(REG_BLUE_OFFSET, OFFSET_BITS'(-64'sd6553600));
        write_reg(REG_BLUE_GAIN, CFG_DATA_BITS'(GAIN_RESET));
        write_reg(REG_SPARE_LO, '1);
        write_reg(REG_SPARE_HI, '1);
        cfg_valid <= 1'b0;
        push_pixel('1, 1'b0, 1'b0);
        push_pixel('0, 1'b0, 1'b0);
        push_pixel('0, 1'b1, 1'b0);
        push_pixel('1, 1'b0, 1'b1);
        push_pixel(16'd100, 1'b1, 1'b1);
        push_pixel(16'd99, 1'b1, 1'b1);
        push_pixel(16'd101, 1'b1, 1'b1);
        wait_drained();

        // zero gain and offset, then opposite signs of offset and gain
        write_reg(REG_RED_OFFSET, '0);
        write_reg(REG_RED_GAIN, '0);
        write_reg(REG_GREEN_OFFSET, OFFSET_MIN);
        write_reg(REG_GREEN_GAIN, CFG_DATA_BITS'(GAIN_MAX));
        write_reg(REG_BLUE_OFFSET, OFFSET_MAX);
        write_reg(REG_BLUE_GAIN, CFG_DATA_BITS'(GAIN_MIN));
        cfg_valid <= 1'b0;
        push_pixel('1, 1'b0, 1'b0);
        push_pixel('1, 1'b1, 1'b0);
        push_pixel('1, 1'b1, 1'b1);
        push_pixel(16'h8000, 1'b1, 1'b1);

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            wait_drained();
            program_random();
            idle_pct <= (ph % 3 == 0) ? 0 : ((ph % 3 == 1) ? 10 : 35);
            if (ph == 2) begin
                // sink goes quiet while pixels keep coming, pipe fills and back-pressures
                hold_token <= hold_token + 1;
            end
            if (ph == 4) begin
                push_random(PHASE_PIXELS / 2);
                wait_drained();
                push_random(PHASE_PIXELS / 2);
            end else begin
                push_random(PHASE_PIXELS);
            end
        end

        wait_drained();
        program_random();
        idle_pct <= 0;
        push_random(CLOSING_PIXELS);
        wait_drained();
        repeat (2 * PIPE_LATENCY + 4) @(posedge aclk);

        if (expected_roots.size() != 0) begin
            $error("%0d results never arrived", expected_roots.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
